// ===== rtl/mpn_pkg.sv =====
// ----------------------------------------------------------------------------
// mpn_pkg
// Shared types, constants and fixed-point helpers of the polynomial neuron.
// ----------------------------------------------------------------------------
package mpn_pkg;

    // Field widths
    localparam int MASK_W    = 4;                 // subset mask / table index
    localparam int DEPTH     = 1 << MASK_W;       // coefficient table entries
    localparam int DATA_W    = 16;                // Q3.12 operand width
    localparam int ACC_W     = 32;                // Q.12 accumulator width
    localparam int FRAC_BITS = 12;
    localparam int NUM_X     = 4;                 // input values per item
    localparam int IDX_W     = 2;                 // index into the input values
    localparam int IN_W      = 88;                // input tdata, byte padded
    localparam int PIPE_W    = 2;                 // drain counter width

    // Drain count at which the accumulator holds the final sum
    localparam logic [PIPE_W-1:0] DRAIN_LAST = 2'd3;

    localparam logic signed [DATA_W-1:0] ONE_Q12 = 16'sd4096;

    // Opcodes carried in tuser
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef logic [NUM_X-1:0][DATA_W-1:0] t_xvec;

    // Mask issued to the product chain
    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
    } t_issue;

    // Chain product handed to the term stage
    typedef struct packed {
        logic                     valid;
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } t_term;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } t_mulres;

    // Q3.12 multiply, floor shift by FRAC_BITS, saturate to 16 bits
    function automatic t_mulres mul_q12(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b);
        logic signed [2*DATA_W-1:0]           prod;
        logic signed [2*DATA_W-FRAC_BITS-1:0] shifted;
        t_mulres                              res;
        prod    = a * b;
        shifted = prod[2*DATA_W-1:FRAC_BITS];
        if (shifted > 20'sd32767) begin
            res.sat   = 1'b1;
            res.value = 16'sh7FFF;
        end else if (shifted < -20'sd32768) begin
            res.sat   = 1'b1;
            res.value = 16'sh8000;
        end else begin
            res.sat   = 1'b0;
            res.value = shifted[DATA_W-1:0];
        end
        return res;
    endfunction

    // Position of the highest set bit of a mask (zero for an empty mask)
    function automatic logic [IDX_W-1:0] top_index(input logic [MASK_W-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int j = 0; j < MASK_W; j++) begin
            if (m[j]) begin
                idx = IDX_W'(j);
            end
        end
        return idx;
    endfunction

    // Mask with its highest set bit cleared
    function automatic logic [MASK_W-1:0] parent_mask(input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] p;
        p = m;
        p[top_index(m)] = 1'b0;
        return p;
    endfunction

endpackage

// ===== rtl/mpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpn_ctrl
// Transaction control: accepts items, walks the subset masks, drains the
// pipeline and hands the finished sum to the output register.
// ----------------------------------------------------------------------------
module mpn_ctrl #(
    parameter int NUM_VARS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    input  logic            i_out_free,
    output logic            o_in_ready,
    output logic            o_start,
    output logic            o_coef_we,
    output logic            o_load,
    output mpn_pkg::t_issue o_issue
);
    import mpn_pkg::*;

    localparam logic [MASK_W-1:0] LastMask = MASK_W'((1 << NUM_VARS) - 1);

    t_state              r_state, n_state;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic [PIPE_W-1:0]   r_drain, n_drain;
    logic                w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_opcode == OPC_EVAL)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_mask == LastMask) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if ((r_drain == DRAIN_LAST) && i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_start       = 1'b0;
        o_coef_we     = 1'b0;
        o_load        = 1'b0;
        o_issue.valid = 1'b0;
        o_issue.mask  = r_mask;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_start    = i_in_valid && (i_opcode == OPC_EVAL);
                o_coef_we  = i_in_valid && (i_opcode == OPC_WRITE);
            end
            ST_RUN: begin
                o_issue.valid = 1'b1;
            end
            ST_DRAIN: begin
                o_load = (r_drain == DRAIN_LAST) && i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Advance the mask counter and the drain counter
    always_comb begin
        n_mask  = r_mask;
        n_drain = r_drain;
        case (r_state)
            ST_IDLE: begin
                n_mask  = '0;
                n_drain = '0;
            end
            ST_RUN: begin
                n_mask = r_mask + 1'b1;
            end
            ST_DRAIN: begin
                if (r_drain != DRAIN_LAST) begin
                    n_drain = r_drain + 1'b1;
                end
            end
            default: begin
                n_mask = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mask  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_drain <= n_drain;
        end
    end

endmodule

// ===== rtl/mpn_coef_mem.sv =====
// ----------------------------------------------------------------------------
// mpn_coef_mem
// Coefficient table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpn_coef_mem (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [mpn_pkg::MASK_W-1:0]                i_waddr,
    input  logic signed [mpn_pkg::DATA_W-1:0]         i_wdata,
    input  logic [mpn_pkg::MASK_W-1:0]                i_raddr,
    output logic signed [mpn_pkg::DATA_W-1:0]         o_rdata
);
    import mpn_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // Store a coefficient, read one every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mpn_chain.sv =====
// ----------------------------------------------------------------------------
// mpn_chain
// Subset product chain: the product of a mask is the product of its parent
// mask (highest bit cleared) times the input of that highest bit. Products
// live in a 16-entry memory, read back for later masks.
// ----------------------------------------------------------------------------
module mpn_chain (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  mpn_pkg::t_xvec               i_x,
    input  mpn_pkg::t_issue              i_issue,
    output logic [mpn_pkg::MASK_W-1:0]   o_coef_raddr,
    output mpn_pkg::t_term               o_term
);
    import mpn_pkg::*;

    t_xvec                    r_x;
    logic signed [DATA_W-1:0] r_prod_mem [DEPTH];
    logic signed [DATA_W-1:0] r_prod_q;
    logic                     r_s1_valid;
    logic [MASK_W-1:0]        r_s1_mask;
    logic                     r_s1_fwd;
    t_term                    r_term;

    logic [MASK_W-1:0]        w_issue_parent;
    logic [MASK_W-1:0]        w_s1_parent;
    logic signed [DATA_W-1:0] w_operand;
    logic signed [DATA_W-1:0] w_x_sel;
    t_mulres                  w_mul;
    t_term                    n_term;

    // Hold the input values of the running evaluation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
        end
    end

    assign w_issue_parent = parent_mask(i_issue.mask);

    // Read the parent product; write the new product back
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_prod_mem[r_s1_mask] <= n_term.value;
        end
        r_prod_q <= r_prod_mem[w_issue_parent];
    end

    // Stage 1 control; forward when the parent is the mask just ahead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue.valid;
        end
        r_s1_mask <= i_issue.mask;
        r_s1_fwd  <= r_s1_valid && (w_issue_parent == r_s1_mask);
    end

    // Multiply the parent product by the input of the highest mask bit
    always_comb begin
        w_s1_parent = parent_mask(r_s1_mask);
        w_x_sel     = $signed(r_x[top_index(r_s1_mask)]);
        if (w_s1_parent == '0) begin
            w_operand = ONE_Q12;
        end else if (r_s1_fwd) begin
            w_operand = r_term.value;
        end else begin
            w_operand = r_prod_q;
        end
        w_mul        = mul_q12(w_operand, w_x_sel);
        n_term.valid = r_s1_valid;
        if (r_s1_mask == '0) begin
            n_term.value = ONE_Q12;
            n_term.sat   = 1'b0;
        end else begin
            n_term.value = w_mul.value;
            n_term.sat   = w_mul.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term.valid <= 1'b0;
        end else begin
            r_term.valid <= n_term.valid;
        end
        r_term.sat   <= n_term.sat;
        r_term.value <= n_term.value;
    end

    assign o_coef_raddr = r_s1_mask;
    assign o_term       = r_term;

endmodule

// ===== rtl/mpn_accum.sv =====
// ----------------------------------------------------------------------------
// mpn_accum
// Term stage and accumulator: multiplies the chain product by its
// coefficient and adds the term into a saturating 32-bit sum.
// ----------------------------------------------------------------------------
module mpn_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  mpn_pkg::t_term                      i_term,
    input  logic signed [mpn_pkg::DATA_W-1:0]   i_coef,
    output logic signed [mpn_pkg::ACC_W-1:0]    o_acc,
    output logic                                o_sat
);
    import mpn_pkg::*;

    localparam logic signed [ACC_W:0] AccMax = (ACC_W+1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [ACC_W:0] AccMin = (ACC_W+1)'(33'sh1_8000_0000);

    t_mulres                  w_mul;
    logic signed [DATA_W-1:0] r_p;
    logic                     r_p_valid;
    logic                     r_p_sat;
    logic signed [ACC_W:0]    w_sum;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_sat, n_sat;

    // Multiply by the coefficient
    assign w_mul = mul_q12(i_term.value, i_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_term.valid;
        end
        r_p     <= w_mul.value;
        r_p_sat <= i_term.sat || w_mul.sat;
    end

    // Add the term and clamp to 32 bits
    always_comb begin
        w_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_p);
        n_acc = r_acc;
        n_sat = r_sat;
        if (i_start) begin
            n_acc = '0;
            n_sat = 1'b0;
        end else if (r_p_valid) begin
            n_sat = r_sat || r_p_sat;
            if (w_sum > AccMax) begin
                n_acc = AccMax[ACC_W-1:0];
                n_sat = 1'b1;
            end else if (w_sum < AccMin) begin
                n_acc = AccMin[ACC_W-1:0];
                n_sat = 1'b1;
            end else begin
                n_acc = w_sum[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_sat <= n_sat;
    end

    assign o_acc = r_acc;
    assign o_sat = r_sat;

endmodule

// ===== rtl/multilinear_poly_neuron_eval.sv =====
// ----------------------------------------------------------------------------
// multilinear_poly_neuron_eval
// Polynomial neuron over NUM_VARS signed Q3.12 inputs.
// ----------------------------------------------------------------------------
// A transaction with tuser 0 writes coeff_value into the coefficient table at
// coeff_index and returns nothing. A transaction with
// tuser 1 evaluates the sum over all subset masks of coefficient times the
// product of the selected inputs, and returns the saturated Q.12 sum in
// m_axis_tdata with the saturation flag in m_axis_tuser. Every coefficient
// that an evaluation reads must have been written first. An evaluation walks
// the 2^NUM_VARS masks one per cycle through a four-stage
// read/multiply/multiply/accumulate pipeline, and the block is ready again
// once the finished sum has been loaded into the output register, which
// waits until the previous result has been taken. Each subset product
// is built from the stored product of its parent mask, so one multiplier
// per stage serves the whole evaluation.
// ----------------------------------------------------------------------------
module multilinear_poly_neuron_eval #(
    parameter int NUM_VARS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] coeff_index, [19:4] coeff_value, [35:20] x0, [51:36] x1,
    // [67:52] x2, [83:68] x3, [87:84] zero
    input  logic [87:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result_value
    output logic [31:0] m_axis_tdata,
    // [0] saturated
    output logic        m_axis_tuser
);
    import mpn_pkg::*;

    t_issue                   w_issue;
    t_term                    w_term;
    t_xvec                    w_x;
    logic                     w_start;
    logic                     w_coef_we;
    logic                     w_load;
    logic                     w_out_free;
    logic [MASK_W-1:0]        w_coef_raddr;
    logic signed [DATA_W-1:0] w_coef_q;
    logic signed [ACC_W-1:0]  w_acc;
    logic                     w_sat;

    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_out_data;
    logic                     r_out_sat;

    // Unpack the input values
    always_comb begin
        for (int j = 0; j < NUM_X; j++) begin
            w_x[j] = s_axis_tdata[20 + DATA_W*j +: DATA_W];
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    mpn_ctrl #(
        .NUM_VARS (NUM_VARS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .i_out_free (w_out_free),
        .o_in_ready (s_axis_tready),
        .o_start    (w_start),
        .o_coef_we  (w_coef_we),
        .o_load     (w_load),
        .o_issue    (w_issue)
    );

    mpn_coef_mem u_coef_mem (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (s_axis_tdata[3:0]),
        .i_wdata (s_axis_tdata[19:4]),
        .i_raddr (w_coef_raddr),
        .o_rdata (w_coef_q)
    );

    mpn_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_x          (w_x),
        .i_issue      (w_issue),
        .o_coef_raddr (w_coef_raddr),
        .o_term       (w_term)
    );

    mpn_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_term  (w_term),
        .i_coef  (w_coef_q),
        .o_acc   (w_acc),
        .o_sat   (w_sat)
    );

    // Output register: load the finished sum, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_data <= w_acc;
            r_out_sat  <= w_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

endmodule
